@@ rtl/wme_pkg.sv @@
// ----------------------------------------------------------------------------
// wme_pkg
// Types, constants and helper functions shared by the edge detector files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wme_pkg;

  localparam int MAX_LINE_WIDTH_DEF = 2048;
  localparam int MAX_FRAME_HEIGHT   = 2048;

  localparam int PIX_W   = 8;
  localparam int ROW_W   = 11;
  localparam int OCOL_W  = 11;
  localparam int CFG_W   = 12;
  localparam int CFG_IX_W = 2;
  localparam int FRM_W   = 8;

  localparam logic [CFG_IX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IX_W-1:0] REG_SKIP_FRAMES  = 2'd2;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;
  localparam logic [FRM_W-1:0] SKIP_FRAMES_RST  = 8'd30;
  localparam logic [FRM_W-1:0] FRAMES_SAT       = 8'd255;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } in_req_t;

  typedef struct packed {
    logic [PIX_W-1:0]  edge_value;
    logic [ROW_W-1:0]  out_row;
    logic [OCOL_W-1:0] out_col;
  } out_res_t;

  typedef struct packed {
    logic live;
    logic emit;
  } scan_ctl_t;

  typedef logic [2:0][PIX_W-1:0] win_col_t;

  function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [PIX_W-1:0] max_pix(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b);
    max_pix = (a > b) ? a : b;
  endfunction

endpackage

`default_nettype wire

@@ rtl/wme_line_buf.sv @@
// ----------------------------------------------------------------------------
// wme_line_buf
// Upper and middle line stores with registered read and same-address bypass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wme_line_buf #(
  parameter int DEPTH = wme_pkg::MAX_LINE_WIDTH_DEF,
  parameter int AW    = $clog2(wme_pkg::MAX_LINE_WIDTH_DEF)
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       rd_en,
  input  wire logic [AW-1:0]              rd_addr,
  input  wire logic                       wr_en,
  input  wire logic [AW-1:0]              wr_addr,
  input  wire logic [wme_pkg::PIX_W-1:0]  wr_upper,
  input  wire logic [wme_pkg::PIX_W-1:0]  wr_middle,
  output logic      [wme_pkg::PIX_W-1:0]  rd_upper,
  output logic      [wme_pkg::PIX_W-1:0]  rd_middle
);

  logic [wme_pkg::PIX_W-1:0] upper_mem  [DEPTH];
  logic [wme_pkg::PIX_W-1:0] middle_mem [DEPTH];

  logic [wme_pkg::PIX_W-1:0] upper_q_r, middle_q_r;
  logic [wme_pkg::PIX_W-1:0] byp_upper_r, byp_middle_r;
  logic                      byp_r, byp_nxt;

  assign byp_nxt = rd_en ? (wr_en && (rd_addr == wr_addr)) : byp_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr]  <= wr_upper;
      middle_mem[wr_addr] <= wr_middle;
    end
    if (rd_en) begin
      upper_q_r    <= upper_mem[rd_addr];
      middle_q_r   <= middle_mem[rd_addr];
      byp_upper_r  <= wr_upper;
      byp_middle_r <= wr_middle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else begin
      byp_r <= byp_nxt;
    end
  end

  assign rd_upper  = byp_r ? byp_upper_r  : upper_q_r;
  assign rd_middle = byp_r ? byp_middle_r : middle_q_r;

endmodule

`default_nettype wire

@@ rtl/wme_cell.sv @@
// ----------------------------------------------------------------------------
// wme_cell
// One window column cell: holds three pixels, shifts to its neighbor and
// folds its absolute differences into the running maximum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wme_cell (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      shift_en,
  input  wire wme_pkg::win_col_t         col_in,
  input  wire logic [wme_pkg::PIX_W-1:0] ref_pix,
  input  wire logic [wme_pkg::PIX_W-1:0] max_in,
  output wme_pkg::win_col_t              col_out,
  output logic      [wme_pkg::PIX_W-1:0] max_out
);

  wme_pkg::win_col_t col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (shift_en) begin
      col_r <= col_in;
    end
  end

  always_comb begin
    max_out = max_in;
    for (int i = 0; i < 3; i++) begin
      max_out = wme_pkg::max_pix(max_out, wme_pkg::abs_diff(col_r[i], ref_pix));
    end
  end

  assign col_out = col_r;

endmodule

`default_nettype wire

@@ rtl/wme_scan.sv @@
// ----------------------------------------------------------------------------
// wme_scan
// Configuration registers, raster position counters and frame counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wme_scan #(
  parameter int MAX_LINE_WIDTH = wme_pkg::MAX_LINE_WIDTH_DEF,
  parameter int CW             = $clog2(wme_pkg::MAX_LINE_WIDTH_DEF)
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_wr_en,
  input  wire logic [wme_pkg::CFG_IX_W-1:0] cfg_index,
  input  wire logic [wme_pkg::CFG_W-1:0]    cfg_data,
  input  wire logic                         acc,
  input  wire logic                         frame_start,
  output wme_pkg::scan_ctl_t                ctl,
  output logic      [wme_pkg::ROW_W-1:0]    row,
  output logic      [CW-1:0]                col
);

  localparam int LW = (CW + 1 > wme_pkg::CFG_W) ? CW + 1 : wme_pkg::CFG_W;

  logic [wme_pkg::CFG_W-1:0] fw_r, fw_nxt, fh_r, fh_nxt;
  logic [wme_pkg::FRM_W-1:0] skip_r, skip_nxt, frames_r, frames_nxt;
  logic [CW-1:0]             col_r, col_nxt;
  logic [wme_pkg::ROW_W-1:0] row_r, row_nxt;
  logic                      done_r, done_nxt;

  logic [LW-1:0]             fw_ext, w_eff, col_p1;
  logic [wme_pkg::CFG_W-1:0] h_eff, row_p1;
  logic                      cur_done;

  always_comb begin
    fw_ext = LW'(fw_r);
    if (fw_r == '0) begin
      w_eff = LW'(1);
    end else if (fw_ext > LW'(MAX_LINE_WIDTH)) begin
      w_eff = LW'(MAX_LINE_WIDTH);
    end else begin
      w_eff = fw_ext;
    end
    h_eff = (fh_r > wme_pkg::CFG_W'(wme_pkg::MAX_FRAME_HEIGHT)) ?
            wme_pkg::CFG_W'(wme_pkg::MAX_FRAME_HEIGHT) : fh_r;
  end

  always_comb begin
    col      = frame_start ? '0 : col_r;
    row      = frame_start ? '0 : row_r;
    cur_done = frame_start ? 1'b0 : done_r;
    col_p1   = LW'(col) + LW'(1);
    row_p1   = wme_pkg::CFG_W'(row) + wme_pkg::CFG_W'(1);
    frames_nxt = (frame_start && frames_r != wme_pkg::FRAMES_SAT) ?
                 frames_r + 8'd1 : frames_r;
    ctl.live = !cur_done;
    ctl.emit = !cur_done && (frames_nxt > skip_r) &&
               (row >= wme_pkg::ROW_W'(2)) && (col >= CW'(2)) &&
               (LW'(col) < w_eff) && (wme_pkg::CFG_W'(row) < h_eff);
  end

  always_comb begin
    col_nxt  = col;
    row_nxt  = row;
    done_nxt = cur_done;
    if (!cur_done) begin
      if (col_p1 >= w_eff) begin
        col_nxt = '0;
        if (row_p1 >= h_eff) begin
          done_nxt = 1'b1;
        end else begin
          row_nxt = row_p1[wme_pkg::ROW_W-1:0];
        end
      end else begin
        col_nxt = col_p1[CW-1:0];
      end
    end
  end

  always_comb begin
    fw_nxt   = fw_r;
    fh_nxt   = fh_r;
    skip_nxt = skip_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        wme_pkg::REG_FRAME_WIDTH:  fw_nxt   = cfg_data;
        wme_pkg::REG_FRAME_HEIGHT: fh_nxt   = cfg_data;
        wme_pkg::REG_SKIP_FRAMES:  skip_nxt = cfg_data[wme_pkg::FRM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r     <= wme_pkg::FRAME_WIDTH_RST;
      fh_r     <= wme_pkg::FRAME_HEIGHT_RST;
      skip_r   <= wme_pkg::SKIP_FRAMES_RST;
      col_r    <= '0;
      row_r    <= '0;
      done_r   <= 1'b0;
      frames_r <= '0;
    end else begin
      fw_r   <= fw_nxt;
      fh_r   <= fh_nxt;
      skip_r <= skip_nxt;
      if (acc) begin
        col_r    <= col_nxt;
        row_r    <= row_nxt;
        done_r   <= done_nxt;
        frames_r <= frames_nxt;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/window_max_abs_diff_edge.sv @@
// ----------------------------------------------------------------------------
// window_max_abs_diff_edge
// 3x3 window maximum absolute difference edge detector on a luma raster.
// ----------------------------------------------------------------------------
// An accepted pixel passes through the s1 registers, then the output register.
// Throughput: one pixel per cycle while the output is not stalled, set by the
// single read and write per cycle of each line store and the window cell shift.
// Reset: counters, frame count and window cells clear, registers take their
// defaults; line stores are not cleared and hold no reset value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module window_max_abs_diff_edge #(
  parameter int MAX_LINE_WIDTH = wme_pkg::MAX_LINE_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire wme_pkg::in_req_t             in_req,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output wme_pkg::out_res_t                 out_res,
  input  wire logic                         cfg_wr_en,
  input  wire logic [wme_pkg::CFG_IX_W-1:0] cfg_index,
  input  wire logic [wme_pkg::CFG_W-1:0]    cfg_data
);

  localparam int CW = $clog2(MAX_LINE_WIDTH);

  wme_pkg::scan_ctl_t        ctl;
  logic [wme_pkg::ROW_W-1:0] scan_row;
  logic [CW-1:0]             scan_col;
  logic                      adv, in_accept, rd_en, wr_en;

  logic                      s1_valid_r, s1_valid_nxt, s1_emit_r;
  logic [wme_pkg::PIX_W-1:0] s1_pix_r;
  logic [wme_pkg::ROW_W-1:0] s1_row_r;
  logic [CW-1:0]             s1_col_r;

  logic [wme_pkg::PIX_W-1:0] rd_upper, rd_middle, head_max, max_c0, edge_max;
  wme_pkg::win_col_t         head_col, col_c0, col_c1;
  logic [CW+10:0]            col_wide;

  logic                      out_valid_r, out_valid_nxt;
  wme_pkg::out_res_t         out_res_r;

  assign adv       = !(out_valid_r && out_stall);
  assign in_stall  = !adv;
  assign in_accept = in_valid && adv;
  assign rd_en     = in_accept && ctl.live;
  assign wr_en     = adv && s1_valid_r;

  wme_scan #(
    .MAX_LINE_WIDTH(MAX_LINE_WIDTH),
    .CW            (CW)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .acc        (in_accept),
    .frame_start(in_req.frame_start),
    .ctl        (ctl),
    .row        (scan_row),
    .col        (scan_col)
  );

  wme_line_buf #(
    .DEPTH(MAX_LINE_WIDTH),
    .AW   (CW)
  ) u_line_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (rd_en),
    .rd_addr  (scan_col),
    .wr_en    (wr_en),
    .wr_addr  (s1_col_r),
    .wr_upper (rd_middle),
    .wr_middle(s1_pix_r),
    .rd_upper (rd_upper),
    .rd_middle(rd_middle)
  );

  assign s1_valid_nxt = adv ? rd_en : s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_emit_r <= ctl.emit;
      s1_pix_r  <= in_req.pixel;
      s1_row_r  <= scan_row;
      s1_col_r  <= scan_col;
    end
  end

  assign head_col = {s1_pix_r, rd_middle, rd_upper};
  assign head_max = wme_pkg::max_pix(wme_pkg::abs_diff(rd_upper, s1_pix_r),
                                     wme_pkg::abs_diff(rd_middle, s1_pix_r));

  wme_cell u_cell_c1 (
    .clk     (clk),
    .rst_n   (rst_n),
    .shift_en(wr_en),
    .col_in  (head_col),
    .ref_pix (s1_pix_r),
    .max_in  (head_max),
    .col_out (col_c0),
    .max_out (max_c0)
  );

  wme_cell u_cell_c2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .shift_en(wr_en),
    .col_in  (col_c0),
    .ref_pix (s1_pix_r),
    .max_in  (max_c0),
    .col_out (col_c1),
    .max_out (edge_max)
  );

  assign col_wide      = {11'b0, s1_col_r};
  assign out_valid_nxt = adv ? (s1_valid_r && s1_emit_r) : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r && s1_emit_r) begin
      out_res_r.edge_value <= edge_max;
      out_res_r.out_row    <= s1_row_r;
      out_res_r.out_col    <= col_wide[wme_pkg::OCOL_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

`default_nettype wire

@@ rtl/wme_checker.sv @@
// ----------------------------------------------------------------------------
// wme_checker
// Port-level checks on the edge detector, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wme_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire wme_pkg::out_res_t out_res
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_res))
    else $error("stalled result request changed");

  a_window_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_res.out_row >= 11'd2) && (out_res.out_col >= 11'd2))
    else $error("result without a full window");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output free");

endmodule

bind window_max_abs_diff_edge wme_checker u_wme_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_res  (out_res)
);

`default_nettype wire
